// ===== rtl/core/rmic_pkg.sv =====
package rmic_pkg;

    localparam int CFG_BITS = 16;

    typedef logic [1:0] mode_t;

    localparam mode_t MODE_STOP   = 2'd0;
    localparam mode_t MODE_OPEN   = 2'd1;
    localparam mode_t MODE_CLOSE  = 2'd2;
    localparam mode_t MODE_SWITCH = 2'd3;

    localparam logic [1:0] KIND_LIGHT = 2'd0;
    localparam logic [1:0] KIND_MOTOR = 2'd1;

    localparam logic [2:0] DEV_LIGHT_ONE  = 3'd0;
    localparam logic [2:0] DEV_LIGHT_ALL  = 3'd1;
    localparam logic [2:0] DEV_CURTAIN    = 3'd2;
    localparam logic [2:0] DEV_SCREEN     = 3'd3;

    localparam logic [2:0] ACT_OFF   = 3'd0;
    localparam logic [2:0] ACT_ON    = 3'd1;
    localparam logic [2:0] ACT_OPEN  = 3'd2;
    localparam logic [2:0] ACT_CLOSE = 3'd3;
    localparam logic [2:0] ACT_STOP  = 3'd4;

    localparam logic [1:0] REG_DEAD_TIME   = 2'd0;
    localparam logic [1:0] REG_RUN_LIMIT   = 2'd1;
    localparam logic [1:0] REG_ACTIVE_LOW  = 2'd2;

    localparam logic [CFG_BITS-1:0] DEAD_TIME_RESET = 16'd150;
    localparam logic [CFG_BITS-1:0] RUN_LIMIT_RESET = 16'd25000;

    typedef struct packed {
        logic                step;
        logic                tick;
        logic                hit;
        logic                go_close;
        logic                go_stop;
    } motor_ctl_t;

endpackage

// ===== rtl/core/rmic_motor.sv =====
module rmic_motor
    import rmic_pkg::*;
#(
    parameter int TIMER_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  motor_ctl_t          ctl,
    input  logic [CFG_BITS-1:0] dead_time,
    input  logic [CFG_BITS-1:0] run_limit,
    output mode_t               mode_next
);

    localparam int CMP_BITS = (TIMER_BITS > CFG_BITS) ? TIMER_BITS : CFG_BITS;
    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};

    mode_t                  mode_reg;
    logic                   pending_reg;
    logic                   pending_next;
    logic [TIMER_BITS-1:0]  timer_reg;
    logic [TIMER_BITS-1:0]  timer_next;
    logic [TIMER_BITS-1:0]  timer_inc;
    logic [CMP_BITS-1:0]    timer_cmp;
    logic [CMP_BITS-1:0]    dead_cmp;
    logic [CMP_BITS-1:0]    run_cmp;
    mode_t                  run_dir;

    assign timer_inc = (timer_reg != TIMER_MAX) ? timer_reg + 1'b1 : timer_reg;
    assign timer_cmp = CMP_BITS'(timer_inc);
    assign dead_cmp  = CMP_BITS'(dead_time);
    assign run_cmp   = CMP_BITS'(run_limit);

    always_comb
    begin
        mode_next    = mode_reg;
        pending_next = pending_reg;
        timer_next   = timer_reg;
        run_dir      = pending_reg ? MODE_CLOSE : MODE_OPEN;
        if (ctl.hit)
        begin
            timer_next = '0;
            if (ctl.go_stop)
            begin
                mode_next = MODE_STOP;
            end
            else
            begin
                pending_next = ctl.go_close;
                if (dead_time == '0)
                begin
                    mode_next = ctl.go_close ? MODE_CLOSE : MODE_OPEN;
                end
                else
                begin
                    mode_next = MODE_SWITCH;
                end
            end
        end
        else if (ctl.tick && (mode_reg != MODE_STOP))
        begin
            timer_next = timer_inc;
            if (mode_reg == MODE_SWITCH)
            begin
                if (timer_cmp >= dead_cmp)
                begin
                    mode_next  = run_dir;
                    timer_next = '0;
                end
            end
            else if (timer_cmp >= run_cmp)
            begin
                mode_next  = MODE_STOP;
                timer_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_STOP;
            pending_reg <= 1'b0;
            timer_reg   <= '0;
        end
        else if (ctl.step)
        begin
            mode_reg    <= mode_next;
            pending_reg <= pending_next;
            timer_reg   <= timer_next;
        end
    end

endmodule

// ===== rtl/core/relay_motor_interlock_controller_unit.sv =====
// Throughput: one beat per cycle unless result_stall holds the result;
// input register, then the light and two motor updates in one pass into
// the result register.
// Reset (rst_n, async, active low): registers back to 150 / 25000 / active
// high, light off, both motors stopped with cleared timers, pipeline empty.
module relay_motor_interlock_controller_unit
    import rmic_pkg::*;
#(
    parameter int TIMER_BITS = 16
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [1:0]          cfg_index,
    input  logic [CFG_BITS-1:0] cfg_data,
    input  logic                item_valid,
    output logic                item_stall,
    input  logic                cmd,
    input  logic [1:0]          kind,
    input  logic [2:0]          device,
    input  logic [2:0]          action,
    output logic                result_valid,
    input  logic                result_stall,
    output logic                status,
    output logic                light_out,
    output logic                curtain_open_out,
    output logic                curtain_close_out,
    output logic                screen_up_out,
    output logic                screen_down_out,
    output logic                light_is_on,
    output logic [1:0]          curtain_status,
    output logic [1:0]          screen_status
);

    logic [CFG_BITS-1:0] dead_time_reg;
    logic [CFG_BITS-1:0] run_limit_reg;
    logic                active_low_reg;

    logic                s1_valid_reg;
    logic                s1_cmd_reg;
    logic [1:0]          s1_kind_reg;
    logic [2:0]          s1_device_reg;
    logic [2:0]          s1_action_reg;

    logic                light_on_reg;
    logic                light_on_next;
    logic                out_valid_reg;
    logic                advance;
    logic                item_take;
    logic                light_ok;
    logic                motor_ok;
    logic                status_next;
    motor_ctl_t          curtain_ctl;
    motor_ctl_t          screen_ctl;
    mode_t               curtain_mode;
    mode_t               screen_mode;

    logic                status_reg;
    logic                light_out_reg;
    logic                curtain_open_reg;
    logic                curtain_close_reg;
    logic                screen_up_reg;
    logic                screen_down_reg;
    logic                light_is_on_reg;
    logic [1:0]          curtain_status_reg;
    logic [1:0]          screen_status_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_time_reg  <= DEAD_TIME_RESET;
            run_limit_reg  <= RUN_LIMIT_RESET;
            active_low_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_DEAD_TIME:  dead_time_reg  <= cfg_data;
                REG_RUN_LIMIT:  run_limit_reg  <= cfg_data;
                REG_ACTIVE_LOW: active_low_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    assign advance    = s1_valid_reg && (!out_valid_reg || !result_stall);
    assign item_stall = s1_valid_reg && out_valid_reg && result_stall;
    assign item_take  = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (item_take)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
        begin
            s1_cmd_reg    <= cmd;
            s1_kind_reg   <= kind;
            s1_device_reg <= device;
            s1_action_reg <= action;
        end
    end

    assign light_ok = (s1_kind_reg == KIND_LIGHT)
                   && ((s1_device_reg == DEV_LIGHT_ONE) || (s1_device_reg == DEV_LIGHT_ALL))
                   && ((s1_action_reg == ACT_OFF) || (s1_action_reg == ACT_ON));
    assign motor_ok = (s1_kind_reg == KIND_MOTOR)
                   && ((s1_device_reg == DEV_CURTAIN) || (s1_device_reg == DEV_SCREEN))
                   && ((s1_action_reg == ACT_OPEN) || (s1_action_reg == ACT_CLOSE)
                       || (s1_action_reg == ACT_STOP));

    assign status_next   = s1_cmd_reg && !light_ok && !motor_ok;
    assign light_on_next = (s1_cmd_reg && light_ok) ? (s1_action_reg == ACT_ON) : light_on_reg;

    always_comb
    begin
        curtain_ctl.step     = advance;
        curtain_ctl.tick     = !s1_cmd_reg;
        curtain_ctl.hit      = s1_cmd_reg && motor_ok && (s1_device_reg == DEV_CURTAIN);
        curtain_ctl.go_close = (s1_action_reg == ACT_CLOSE);
        curtain_ctl.go_stop  = (s1_action_reg == ACT_STOP);
        screen_ctl           = curtain_ctl;
        screen_ctl.hit       = s1_cmd_reg && motor_ok && (s1_device_reg == DEV_SCREEN);
    end

    rmic_motor #(
        .TIMER_BITS (TIMER_BITS)
    ) u_curtain (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (curtain_ctl),
        .dead_time  (dead_time_reg),
        .run_limit  (run_limit_reg),
        .mode_next  (curtain_mode)
    );

    rmic_motor #(
        .TIMER_BITS (TIMER_BITS)
    ) u_screen (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (screen_ctl),
        .dead_time  (dead_time_reg),
        .run_limit  (run_limit_reg),
        .mode_next  (screen_mode)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_on_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                light_on_reg <= light_on_next;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            status_reg         <= status_next;
            light_out_reg      <= light_on_next ^ active_low_reg;
            curtain_open_reg   <= (curtain_mode == MODE_OPEN) ^ active_low_reg;
            curtain_close_reg  <= (curtain_mode == MODE_CLOSE) ^ active_low_reg;
            screen_up_reg      <= (screen_mode == MODE_OPEN) ^ active_low_reg;
            screen_down_reg    <= (screen_mode == MODE_CLOSE) ^ active_low_reg;
            light_is_on_reg    <= light_on_next;
            curtain_status_reg <= (curtain_mode == MODE_SWITCH) ? MODE_STOP : curtain_mode;
            screen_status_reg  <= (screen_mode == MODE_SWITCH) ? MODE_STOP : screen_mode;
        end
    end

    assign result_valid      = out_valid_reg;
    assign status            = status_reg;
    assign light_out         = light_out_reg;
    assign curtain_open_out  = curtain_open_reg;
    assign curtain_close_out = curtain_close_reg;
    assign screen_up_out     = screen_up_reg;
    assign screen_down_out   = screen_down_reg;
    assign light_is_on       = light_is_on_reg;
    assign curtain_status    = curtain_status_reg;
    assign screen_status     = screen_status_reg;

`ifndef SYNTH
    a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid)
        else $error("beat left stage 1 but no result followed");

    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled with free pipeline");

    a_tick_keeps_light: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && !s1_cmd_reg) |=> (light_on_reg == $past(light_on_reg)))
        else $error("tick changed the light");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> result_valid)
        else $error("stalled result dropped");
`endif

endmodule

// ===== tb/sv/tb_relay_motor_interlock_controller_unit.sv =====
`timescale 1ns / 1ps

module tb_relay_motor_interlock_controller_unit;
    import rmic_pkg::*;

    localparam int TIMER_BITS    = 16;
    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASE_BEATS   = 200;
    localparam int LONG_TICKS    = 100;

    localparam logic [1:0] REG_UNUSED      = 2'd3;
    localparam logic [1:0] KIND_RESERVED_2 = 2'd2;
    localparam logic [1:0] KIND_RESERVED_3 = 2'd3;
    localparam logic [2:0] DEV_RESERVED_LO = 3'd4;
    localparam logic [2:0] DEV_RESERVED_HI = 3'd7;
    localparam logic [2:0] ACT_RESERVED_LO = 3'd5;
    localparam logic [2:0] ACT_RESERVED_HI = 3'd7;

    typedef struct packed {
        logic       status;
        logic       light_out;
        logic       curtain_open_out;
        logic       curtain_close_out;
        logic       screen_up_out;
        logic       screen_down_out;
        logic       light_is_on;
        logic [1:0] curtain_status;
        logic [1:0] screen_status;
    } relay_view_t;

    class interlock_tracker;
        logic [CFG_BITS-1:0]   dead_time;
        logic [CFG_BITS-1:0]   run_limit;
        logic                  active_low;
        logic                  light_on;
        mode_t                 mode [2];
        logic                  close_next [2];
        logic [TIMER_BITS-1:0] timer [2];
        relay_view_t           pending_views [$];
        int unsigned           mismatches = 0;

        function void reset_state();
            dead_time  = DEAD_TIME_RESET;
            run_limit  = RUN_LIMIT_RESET;
            active_low = 1'b0;
            light_on   = 1'b0;
            for (int m = 0; m < 2; m++)
            begin
                mode[m]       = MODE_STOP;
                close_next[m] = 1'b0;
                timer[m]      = '0;
            end
        endfunction

        function void write_reg(logic [1:0] idx, logic [CFG_BITS-1:0] data);
            case (idx)
                REG_DEAD_TIME:  dead_time  = data;
                REG_RUN_LIMIT:  run_limit  = data;
                REG_ACTIVE_LOW: active_low = data[0];
                default: ;
            endcase
        endfunction

        function void start_run(int m);
            mode[m]  = close_next[m] ? MODE_CLOSE : MODE_OPEN;
            timer[m] = '0;
        endfunction

        function void advance(int m);
            if (mode[m] == MODE_STOP)
                return;
            if (timer[m] != '1)
                timer[m]++;
            if (mode[m] == MODE_SWITCH)
            begin
                if (timer[m] >= dead_time)
                    start_run(m);
            end
            else if (timer[m] >= run_limit)
            begin
                mode[m]  = MODE_STOP;
                timer[m] = '0;
            end
        endfunction

        function logic apply_command(logic [1:0] k, logic [2:0] d, logic [2:0] a);
            int m;
            if (k == KIND_LIGHT)
            begin
                if ((d != DEV_LIGHT_ONE && d != DEV_LIGHT_ALL) || (a != ACT_OFF && a != ACT_ON))
                    return 1'b1;
                light_on = (a == ACT_ON);
                return 1'b0;
            end
            if (k != KIND_MOTOR)
                return 1'b1;
            if (a != ACT_OPEN && a != ACT_CLOSE && a != ACT_STOP)
                return 1'b1;
            if (d != DEV_CURTAIN && d != DEV_SCREEN)
                return 1'b1;
            m = (d == DEV_SCREEN) ? 1 : 0;
            mode[m]  = MODE_STOP;
            timer[m] = '0;
            if (a == ACT_STOP)
                return 1'b0;
            close_next[m] = (a == ACT_CLOSE);
            if (dead_time == '0)
                start_run(m);
            else
                mode[m] = MODE_SWITCH;
            return 1'b0;
        endfunction

        function void take_item(logic c, logic [1:0] k, logic [2:0] d, logic [2:0] a);
            relay_view_t v;
            v.status = 1'b0;
            if (!c)
            begin
                advance(0);
                advance(1);
            end
            else
                v.status = apply_command(k, d, a);
            v.light_out         = light_on ^ active_low;
            v.curtain_open_out  = (mode[0] == MODE_OPEN) ^ active_low;
            v.curtain_close_out = (mode[0] == MODE_CLOSE) ^ active_low;
            v.screen_up_out     = (mode[1] == MODE_OPEN) ^ active_low;
            v.screen_down_out   = (mode[1] == MODE_CLOSE) ^ active_low;
            v.light_is_on       = light_on;
            v.curtain_status    = (mode[0] == MODE_SWITCH) ? MODE_STOP : mode[0];
            v.screen_status     = (mode[1] == MODE_SWITCH) ? MODE_STOP : mode[1];
            pending_views.push_back(v);
        endfunction

        function void field_check(string name, int unsigned e, int unsigned a);
            if (e !== a)
            begin
                $display("%0t: %s expected %0d got %0d", $time, name, e, a);
                mismatches++;
            end
        endfunction

        function void match_outputs(relay_view_t got);
            relay_view_t e;
            if (pending_views.size() == 0)
            begin
                $display("%0t: result beat with nothing outstanding", $time);
                mismatches++;
                return;
            end
            e = pending_views.pop_front();
            field_check("status", e.status, got.status);
            field_check("light_out", e.light_out, got.light_out);
            field_check("curtain_open_out", e.curtain_open_out, got.curtain_open_out);
            field_check("curtain_close_out", e.curtain_close_out, got.curtain_close_out);
            field_check("screen_up_out", e.screen_up_out, got.screen_up_out);
            field_check("screen_down_out", e.screen_down_out, got.screen_down_out);
            field_check("light_is_on", e.light_is_on, got.light_is_on);
            field_check("curtain_status", e.curtain_status, got.curtain_status);
            field_check("screen_status", e.screen_status, got.screen_status);
        endfunction
    endclass

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [1:0]          cfg_index;
    logic [CFG_BITS-1:0] cfg_data;
    logic                item_valid;
    logic                item_stall;
    logic                cmd;
    logic [1:0]          kind;
    logic [2:0]          device;
    logic [2:0]          action;
    logic                result_valid;
    logic                result_stall;
    logic                status;
    logic                light_out;
    logic                curtain_open_out;
    logic                curtain_close_out;
    logic                screen_up_out;
    logic                screen_down_out;
    logic                light_is_on;
    logic [1:0]          curtain_status;
    logic [1:0]          screen_status;

    interlock_tracker tracker;
    int               burst_left;
    bit               bursty;
    bit               stall_enable;
    int unsigned      stall_style;
    int unsigned      cycle_count;
    int unsigned      quiet_cycles;

    relay_motor_interlock_controller_unit dut (.*);

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // beat monitor: results checked before the new input is predicted
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (result_valid && !result_stall)
                tracker.match_outputs({status, light_out, curtain_open_out, curtain_close_out,
                                       screen_up_out, screen_down_out, light_is_on,
                                       curtain_status, screen_status});
            if (item_valid && !item_stall)
                tracker.take_item(cmd, kind, device, action);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count % 128 == 0)
            stall_style = $urandom_range(0, 3);
        if (!stall_enable)
            result_stall <= 1'b0;
        else
            case (stall_style)
                0: result_stall <= 1'b0;
                1: result_stall <= ($urandom_range(0, 2) == 0);
                2: result_stall <= cycle_count[0];
                default: result_stall <= (cycle_count[3:2] == 2'd0);
            endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    task automatic send_beat(input logic c, input logic [1:0] k, input logic [2:0] d,
                             input logic [2:0] a);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 12);
            gap = 0;
            if (bursty)
                gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30)
                                                  : $urandom_range(0, 4);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid <= 1'b1;
        cmd        <= c;
        kind       <= k;
        device     <= d;
        action     <= a;
        do @(posedge clk); while (item_stall);
    endtask

    task automatic send_random(input int unsigned tick_pct);
        int unsigned r;
        logic [2:0]  a;
        r = $urandom_range(0, 99);
        case ($urandom_range(0, 2))
            0: a = ACT_OPEN;
            1: a = ACT_CLOSE;
            default: a = ACT_STOP;
        endcase
        if (r < tick_pct)
            send_beat(1'b0, 2'($urandom), 3'($urandom), 3'($urandom));
        else if (r < tick_pct + (100 - tick_pct) * 6 / 10)
            send_beat(1'b1, KIND_MOTOR, $urandom_range(0, 1) ? DEV_SCREEN : DEV_CURTAIN, a);
        else if (r < tick_pct + (100 - tick_pct) * 8 / 10)
            send_beat(1'b1, KIND_LIGHT, $urandom_range(0, 1) ? DEV_LIGHT_ALL : DEV_LIGHT_ONE,
                      $urandom_range(0, 1) ? ACT_ON : ACT_OFF);
        else
            send_beat(1'b1, 2'($urandom), 3'($urandom), 3'($urandom));
    endtask

    task automatic drain();
        item_valid <= 1'b0;
        burst_left = 0;
        do @(posedge clk); while (tracker.pending_views.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic apply_setting(input logic [CFG_BITS-1:0] dt, input logic [CFG_BITS-1:0] rl,
                                 input logic pol);
        logic [CFG_BITS-1:0] pol_word;
        logic [CFG_BITS-1:0] junk;
        pol_word = CFG_BITS'($urandom);
        pol_word[0] = pol;
        junk = CFG_BITS'($urandom);
        cfg_we    <= 1'b1;
        cfg_index <= REG_DEAD_TIME;
        cfg_data  <= dt;
        @(posedge clk);
        cfg_index <= REG_RUN_LIMIT;
        cfg_data  <= rl;
        @(posedge clk);
        cfg_index <= REG_ACTIVE_LOW;
        cfg_data  <= pol_word;
        @(posedge clk);
        cfg_index <= REG_UNUSED;
        cfg_data  <= junk;
        @(posedge clk);
        cfg_we <= 1'b0;
        tracker.write_reg(REG_DEAD_TIME, dt);
        tracker.write_reg(REG_RUN_LIMIT, rl);
        tracker.write_reg(REG_ACTIVE_LOW, pol_word);
        tracker.write_reg(REG_UNUSED, junk);
    endtask

    task automatic run_phase(input logic [CFG_BITS-1:0] dt, input logic [CFG_BITS-1:0] rl,
                             input logic pol);
        int unsigned tick_pct;
        drain();
        apply_setting(dt, rl, pol);
        bursty       = ($urandom_range(0, 3) != 0);
        stall_enable = ($urandom_range(0, 3) != 0);
        tick_pct     = $urandom_range(0, 1) ? 55 : 85;
        send_beat(1'b1, KIND_MOTOR, DEV_CURTAIN, ACT_OPEN);
        send_beat(1'b1, KIND_MOTOR, DEV_SCREEN, ACT_CLOSE);
        send_beat(1'b0, KIND_LIGHT, DEV_LIGHT_ONE, ACT_OFF);
        repeat (PHASE_BEATS) send_random(tick_pct);
    endtask

    initial
    begin
        tracker = new;
        tracker.reset_state();
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_DEAD_TIME;
        cfg_data     <= '0;
        item_valid   <= 1'b0;
        cmd          <= 1'b0;
        kind         <= KIND_LIGHT;
        device       <= DEV_LIGHT_ONE;
        action       <= ACT_OFF;
        result_stall <= 1'b0;
        bursty       = 1'b1;
        stall_enable = 1'b1;
        burst_left   = 0;
        cycle_count  = 0;
        quiet_cycles = 0;
        stall_style  = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // light commands, malformed commands, tick with junk fields
        send_beat(1'b1, KIND_LIGHT, DEV_LIGHT_ONE, ACT_ON);
        send_beat(1'b1, KIND_LIGHT, DEV_LIGHT_ALL, ACT_OFF);
        send_beat(1'b1, KIND_LIGHT, DEV_LIGHT_ALL, ACT_ON);
        send_beat(1'b1, KIND_LIGHT, DEV_CURTAIN, ACT_OFF);
        send_beat(1'b1, KIND_LIGHT, DEV_LIGHT_ONE, ACT_OPEN);
        send_beat(1'b1, KIND_RESERVED_2, DEV_LIGHT_ONE, ACT_ON);
        send_beat(1'b1, KIND_RESERVED_3, DEV_RESERVED_HI, ACT_RESERVED_HI);
        send_beat(1'b1, KIND_MOTOR, DEV_CURTAIN, ACT_OFF);
        send_beat(1'b1, KIND_MOTOR, DEV_CURTAIN, ACT_ON);
        send_beat(1'b1, KIND_MOTOR, DEV_SCREEN, ACT_RESERVED_LO);
        send_beat(1'b1, KIND_MOTOR, DEV_SCREEN, ACT_RESERVED_HI);
        send_beat(1'b1, KIND_MOTOR, DEV_LIGHT_ONE, ACT_OPEN);
        send_beat(1'b1, KIND_MOTOR, DEV_LIGHT_ALL, ACT_CLOSE);
        send_beat(1'b1, KIND_MOTOR, DEV_RESERVED_LO, ACT_STOP);
        send_beat(1'b1, KIND_MOTOR, DEV_RESERVED_HI, ACT_OPEN);
        send_beat(1'b0, KIND_RESERVED_3, DEV_RESERVED_HI, ACT_RESERVED_HI);
        // wait replaced by a new command, then stopped
        send_beat(1'b1, KIND_MOTOR, DEV_CURTAIN, ACT_OPEN);
        send_beat(1'b0, KIND_LIGHT, DEV_LIGHT_ONE, ACT_OFF);
        send_beat(1'b1, KIND_MOTOR, DEV_SCREEN, ACT_CLOSE);
        send_beat(1'b0, KIND_LIGHT, DEV_LIGHT_ONE, ACT_OFF);
        send_beat(1'b1, KIND_MOTOR, DEV_CURTAIN, ACT_CLOSE);
        send_beat(1'b1, KIND_MOTOR, DEV_CURTAIN, ACT_STOP);
        send_beat(1'b0, KIND_LIGHT, DEV_LIGHT_ONE, ACT_OFF);
        repeat (150) send_random(55);

        run_phase(16'd0, 16'd1, 1'b1);
        run_phase(16'd3, 16'd10, 1'b0);
        run_phase(16'd0, 16'd0, 1'b1);
        run_phase(16'hFFFF, 16'hFFFF, 1'b0);
        run_phase(16'd1, 16'd5, 1'b1);
        repeat (4)
            run_phase(CFG_BITS'($urandom_range(0, 8)), CFG_BITS'($urandom_range(0, 40)),
                      1'($urandom_range(0, 1)));

        // run at the largest limit, no idling
        drain();
        apply_setting(16'd2, 16'hFFFF, 1'($urandom_range(0, 1)));
        bursty       = 1'b0;
        stall_enable = 1'b0;
        send_beat(1'b1, KIND_MOTOR, DEV_CURTAIN, ACT_OPEN);
        send_beat(1'b1, KIND_MOTOR, DEV_SCREEN, ACT_CLOSE);
        repeat (LONG_TICKS) send_beat(1'b0, 2'($urandom), 3'($urandom), 3'($urandom));
        drain();

        if (tracker.mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
